// ----- rtl/core/rnsr_pkg.sv -----
// ----------------------------------------------------------------------------
// rnsr_pkg
// Shared widths and constants for the rms / newton square root block.
// ----------------------------------------------------------------------------
package rnsr_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int RMS_W    = 16;

    // largest square is 2^30, held in 31 bits
    localparam int SQ_W     = 31;

    // mean square never exceeds 2^30; newton estimates stay in the same range
    localparam int MEAN_W   = 31;

    // bound on newton rounds, never reached in practice
    localparam int NEWTON_ROUND_CAP = 64;
    localparam int ROUND_W          = 7;

    // default block length
    localparam int DEF_MAX_SAMPLES  = 256;

endpackage

// ----- rtl/core/rnsr_accum.sv -----
// ----------------------------------------------------------------------------
// rnsr_accum
// Squares each accepted sample and keeps the running sum and sample count.
// ----------------------------------------------------------------------------
module rnsr_accum import rnsr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = SQ_W + CNT_W - 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    output logic                       close,
    output logic        [SUM_W-1:0]    sum_total,
    output logic        [CNT_W-1:0]    count_total
);

    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] product;
    logic                  full;

    // magnitude and square; the most negative sample maps to 0x8000
    always_comb begin
        mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        product = mag * mag;
    end

    // totals including the sample on the input this cycle
    assign sum_total   = sum_reg + SUM_W'(product[SQ_W-1:0]);
    assign count_total = count_reg + 1'b1;
    assign full        = (count_total == CNT_W'(MAX_SAMPLES));
    assign close       = accept && (last || full);

    // running sum and count, cleared when a block closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (close) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (accept) begin
            sum_reg   <= sum_total;
            count_reg <= count_total;
        end
    end

endmodule

// ----- rtl/core/rnsr_divider.sv -----
// ----------------------------------------------------------------------------
// rnsr_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rnsr_divider #(
    parameter int W = 39
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int STEP_W = $clog2(W + 1);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [W:0]        partial;
    logic [W:0]        trial;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        partial = {rem_reg, quo_reg[W-1]};
        trial   = partial - {1'b0, dsr_reg};
    end

    // control registers: step count and done strobe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= STEP_W'(W);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 1'b1;
                done_reg <= (step_reg == STEP_W'(1));
            end
        end
    end

    // datapath needs no reset
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (step_reg != '0) begin
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= partial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/rms_newton_square_root.sv -----
// ----------------------------------------------------------------------------
// rms_newton_square_root
// RMS of a block of signed samples with an integer newton square root.
// ----------------------------------------------------------------------------
// Samples that do not close a block are accepted one per clock, each adding
// its square to a running sum. The sample marked last, or the one that fills
// the block to MAX_SAMPLES, closes it: the input then stalls while one shared
// radix-2 divider, one quotient bit per cycle, first forms the mean square
// and then, unless the mean square is zero, serves each newton round (at
// most 64 rounds). SUM_W is 39 for the default block of 256 samples. The
// result sits in an output register, and samples of the next block are
// accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module rms_newton_square_root import rnsr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic        [RMS_W-1:0]    m_rms
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SQ_W + CNT_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_NEWTON,
        ST_STEP,
        ST_OUTPUT
    } state_t;

    state_t             state_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [MEAN_W-1:0]  est_reg;
    logic [MEAN_W-1:0]  est_new_reg;
    logic [ROUND_W-1:0] rounds_reg;
    logic [RMS_W-1:0]   root_reg;
    logic [RMS_W-1:0]   prev_root_reg;
    logic               m_valid_reg;
    logic [RMS_W-1:0]   m_rms_reg;

    logic               accept;
    logic               close;
    logic [SUM_W-1:0]   sum_total;
    logic [CNT_W-1:0]   count_total;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [SUM_W-1:0]   div_divisor;
    logic               div_done;
    logic [SUM_W-1:0]   div_quotient;

    logic [MEAN_W-1:0]  mean_q;
    logic [MEAN_W-1:0]  seed;
    logic [MEAN_W:0]    est_sum;
    logic [MEAN_W-1:0]  est_half;
    logic [MEAN_W-1:0]  gap;
    logic               iterate;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // square and accumulate
    rnsr_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .sample      (s_sample),
        .last        (s_last),
        .close       (close),
        .sum_total   (sum_total),
        .count_total (count_total)
    );

    // shared divider for the mean and every newton round
    rnsr_divider #(
        .W (SUM_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // newton arithmetic
    always_comb begin
        mean_q   = div_quotient[MEAN_W-1:0];
        seed     = (prev_root_reg == '0) ? MEAN_W'(1) : MEAN_W'(prev_root_reg);
        est_sum  = {1'b0, est_reg} + {1'b0, mean_q};
        est_half = est_sum[MEAN_W:1];
        gap      = (est_new_reg > est_reg) ? (est_new_reg - est_reg)
                                           : (est_reg - est_new_reg);
        iterate  = (gap > MEAN_W'(1))
                && (rounds_reg < ROUND_W'(NEWTON_ROUND_CAP - 1));
    end

    // divider launch and operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = SUM_W'(mean_reg);
        div_divisor  = SUM_W'(est_new_reg);
        unique case (state_reg)
            ST_IDLE: begin
                div_start    = close;
                div_dividend = sum_total;
                div_divisor  = SUM_W'(count_total);
            end
            ST_MEAN: begin
                div_start    = div_done && (mean_q != '0);
                div_dividend = SUM_W'(mean_q);
                div_divisor  = SUM_W'(seed);
            end
            ST_STEP: begin
                div_start    = iterate;
            end
            ST_NEWTON, ST_OUTPUT: begin
                div_start    = 1'b0;
            end
            default: begin
                div_start    = 1'b0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_root_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // output state handles its own valid update
            if (m_valid_reg && m_ready && (state_reg != ST_OUTPUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (close) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (div_done) begin
                        mean_reg   <= mean_q;
                        est_reg    <= seed;
                        rounds_reg <= '0;
                        if (mean_q == '0) begin
                            root_reg  <= '0;
                            state_reg <= ST_OUTPUT;
                        end else begin
                            state_reg <= ST_NEWTON;
                        end
                    end
                end
                ST_NEWTON: begin
                    if (div_done) begin
                        est_new_reg <= (est_half == '0) ? MEAN_W'(1) : est_half;
                        state_reg   <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (iterate) begin
                        est_reg    <= est_new_reg;
                        rounds_reg <= rounds_reg + 1'b1;
                        state_reg  <= ST_NEWTON;
                    end else begin
                        root_reg  <= est_new_reg[RMS_W-1:0];
                        state_reg <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_rms_reg     <= root_reg;
                        prev_root_reg <= root_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rms   = m_rms_reg;

endmodule

// ----- rtl/core/rnsr_checker.sv -----
// ----------------------------------------------------------------------------
// rnsr_checker
// Port-level checks on the rms / newton square root block.
// ----------------------------------------------------------------------------
module rnsr_checker import rnsr_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_last,
    input logic                m_valid,
    input logic                m_ready,
    input logic [RMS_W-1:0]    m_rms
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rms))
        else $error("stalled result changed");

    // a sample marked last closes the block and stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input still ready after closing transfer");

    // input only stalls after a sample transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("input stalled without a transfer");

    // a new result is only posted out of the computation
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while input was open");

endmodule

bind rms_newton_square_root rnsr_checker u_rnsr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_last  (s_last),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rms   (m_rms)
);
